@@ design/hsvrgb_pkg.sv @@
package hsvrgb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int HUE_W      = 16;
    localparam int SEC_W      = 3;
    localparam int H6_W       = HUE_W + SEC_W;
    localparam int IN_DATA_W  = ((HUE_W + 2 * VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * VAL_W + 7) / 8) * 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [VAL_W-1:0] VAL_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [HUE_W:0]   HUE_ONE = {1'b1, {HUE_W{1'b0}}};

    typedef enum logic [SEC_W-1:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector          sector;
        logic [VAL_W-1:0] sat;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] sf;
        logic [VAL_W-1:0] sg;
    } t_work;

    function automatic logic [VAL_W-1:0] clamp_one(input logic [VAL_W-1:0] x);
        clamp_one = (x > VAL_ONE) ? VAL_ONE : x;
    endfunction

endpackage

@@ design/hsvrgb_front.sv @@
module hsvrgb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]    i_hue,
    input  logic [hsvrgb_pkg::VAL_W-1:0]    i_sat,
    input  logic [hsvrgb_pkg::VAL_W-1:0]    i_val,
    output logic                            o_push,
    input  logic                            i_full,
    output hsvrgb_pkg::t_work               o_work
);

    localparam int SF_W = hsvrgb_pkg::VAL_W + hsvrgb_pkg::HUE_W;
    localparam int SG_W = hsvrgb_pkg::VAL_W + hsvrgb_pkg::HUE_W + 1;

    logic                               r_valid;
    hsvrgb_pkg::t_work                  r_work;
    hsvrgb_pkg::t_work                  n_work;
    logic [hsvrgb_pkg::VAL_W-1:0]       sat_c;
    logic [hsvrgb_pkg::H6_W-1:0]        h6;
    logic [hsvrgb_pkg::HUE_W-1:0]       frac;
    logic [SF_W-1:0]                    sf_prod;
    logic [SG_W-1:0]                    sg_prod;

    // hue times six as two shifted adds
    always_comb begin
        sat_c   = hsvrgb_pkg::clamp_one(i_sat);
        h6      = hsvrgb_pkg::H6_W'({i_hue, 2'b00}) + hsvrgb_pkg::H6_W'({i_hue, 1'b0});
        frac    = h6[hsvrgb_pkg::HUE_W-1:0];
        sf_prod = SF_W'(sat_c) * SF_W'(frac);
        sg_prod = SG_W'(sat_c) * SG_W'(hsvrgb_pkg::HUE_ONE - {1'b0, frac});
        n_work.sector = hsvrgb_pkg::t_sector'(h6[hsvrgb_pkg::H6_W-1:hsvrgb_pkg::HUE_W]);
        n_work.sat    = sat_c;
        n_work.val    = hsvrgb_pkg::clamp_one(i_val);
        n_work.sf     = sf_prod[hsvrgb_pkg::HUE_W +: hsvrgb_pkg::VAL_W];
        n_work.sg     = sg_prod[hsvrgb_pkg::HUE_W +: hsvrgb_pkg::VAL_W];
    end

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

endmodule

@@ design/hsvrgb_fifo.sv @@
module hsvrgb_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hsvrgb_pkg::t_work   i_work,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output hsvrgb_pkg::t_work   o_work
);

    hsvrgb_pkg::t_work                  r_mem [hsvrgb_pkg::FIFO_DEPTH];
    logic [hsvrgb_pkg::FIFO_AW-1:0]     r_wr_ptr;
    logic [hsvrgb_pkg::FIFO_AW-1:0]     r_rd_ptr;
    logic [hsvrgb_pkg::FIFO_CW-1:0]     r_count;
    logic [hsvrgb_pkg::FIFO_CW-1:0]     n_count;

    assign o_full  = (r_count == hsvrgb_pkg::FIFO_CW'(hsvrgb_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        priority if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hsvrgb_pkg::FIFO_CW'(hsvrgb_pkg::FIFO_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
`endif

endmodule

@@ design/hsvrgb_back.sv @@
module hsvrgb_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  hsvrgb_pkg::t_work               i_work,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [hsvrgb_pkg::VAL_W-1:0]    o_red,
    output logic [hsvrgb_pkg::VAL_W-1:0]    o_green,
    output logic [hsvrgb_pkg::VAL_W-1:0]    o_blue
);

    localparam int PROD_W = 2 * hsvrgb_pkg::VAL_W;

    logic                           r_b1_valid;
    hsvrgb_pkg::t_sector            r_sector;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_val;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_p;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_q;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_t;
    logic                           r_out_valid;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_red;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_green;
    logic [hsvrgb_pkg::VAL_W-1:0]   r_blue;
    logic [hsvrgb_pkg::VAL_W-1:0]   n_red;
    logic [hsvrgb_pkg::VAL_W-1:0]   n_green;
    logic [hsvrgb_pkg::VAL_W-1:0]   n_blue;
    logic [PROD_W-1:0]              p_prod;
    logic [PROD_W-1:0]              q_prod;
    logic [PROD_W-1:0]              t_prod;
    logic                           out_ready;
    logic                           b1_ready;

    assign out_ready = !r_out_valid || i_ready;
    assign b1_ready  = !r_b1_valid || out_ready;
    assign o_pop     = i_valid && b1_ready;
    assign o_valid   = r_out_valid;
    assign o_red     = r_red;
    assign o_green   = r_green;
    assign o_blue    = r_blue;

    always_comb begin
        p_prod = PROD_W'(i_work.val) * PROD_W'(hsvrgb_pkg::VAL_ONE - i_work.sat);
        q_prod = PROD_W'(i_work.val) * PROD_W'(hsvrgb_pkg::VAL_ONE - i_work.sf);
        t_prod = PROD_W'(i_work.val) * PROD_W'(hsvrgb_pkg::VAL_ONE - i_work.sg);
    end

    always_comb begin
        unique case (r_sector)
            hsvrgb_pkg::SEC_RED: begin
                n_red = r_val; n_green = r_t;   n_blue = r_p;
            end
            hsvrgb_pkg::SEC_YELLOW: begin
                n_red = r_q;   n_green = r_val; n_blue = r_p;
            end
            hsvrgb_pkg::SEC_GREEN: begin
                n_red = r_p;   n_green = r_val; n_blue = r_t;
            end
            hsvrgb_pkg::SEC_CYAN: begin
                n_red = r_p;   n_green = r_q;   n_blue = r_val;
            end
            hsvrgb_pkg::SEC_BLUE: begin
                n_red = r_t;   n_green = r_p;   n_blue = r_val;
            end
            default: begin
                n_red = r_val; n_green = r_p;   n_blue = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sector <= i_work.sector;
            r_val    <= i_work.val;
            r_p      <= p_prod[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::VAL_W];
            r_q      <= q_prod[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::VAL_W];
            r_t      <= t_prod[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::VAL_W];
        end
        if (out_ready && r_b1_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

`ifndef NO_ASSERTIONS
    a_scaled_below_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b1_valid |-> (r_p <= r_val) && (r_q <= r_val) && (r_t <= r_val))
        else $error("scaled term exceeds value");
`endif

endmodule

@@ design/hsv_to_rgb_converter.sv @@
// HSV to RGB converter: takes one hue, saturation, value word per clock and returns one
// red, green, blue word per clock, sustained with no bubbles while the output is ready.
// An accepted word passes through the front register (clamping, sector, s*f and s*(1-f)
// products), the four-entry queue, the back multiply stage (v*(1-s), v*(1-s*f),
// v*(1-s*(1-f))) and then the output register holding the sector-selected result.
// Front and back stall independently; input ready drops only when the front register is
// full and the queue is full. Saturation and value above 1.0 are clamped to 1.0; results
// never exceed value.
module hsv_to_rgb_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // hue, saturation, brightness, zero pad
    input  logic [hsvrgb_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // red, green, blue, zero pad
    output logic [hsvrgb_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam int SAT_LO = hsvrgb_pkg::HUE_W;
    localparam int VAL_LO = hsvrgb_pkg::HUE_W + hsvrgb_pkg::VAL_W;

    logic                           push;
    logic                           full;
    logic                           pop;
    logic                           q_valid;
    hsvrgb_pkg::t_work              front_work;
    hsvrgb_pkg::t_work              q_work;
    logic [hsvrgb_pkg::VAL_W-1:0]   red;
    logic [hsvrgb_pkg::VAL_W-1:0]   green;
    logic [hsvrgb_pkg::VAL_W-1:0]   blue;

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_hue   (i_s_axis_tdata[hsvrgb_pkg::HUE_W-1:0]),
        .i_sat   (i_s_axis_tdata[SAT_LO +: hsvrgb_pkg::VAL_W]),
        .i_val   (i_s_axis_tdata[VAL_LO +: hsvrgb_pkg::VAL_W]),
        .o_push  (push),
        .i_full  (full),
        .o_work  (front_work)
    );

    hsvrgb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    hsvrgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_work  (q_work),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign o_m_axis_tdata = hsvrgb_pkg::OUT_DATA_W'({blue, green, red});

endmodule
